// ===== src/vtmr_pkg.sv =====
package vtmr_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 38;
   localparam int RULE_W      = 35;
   localparam int REWRITE_W   = 38;

   localparam logic [CSR_INDEX_W-1:0] CSR_MATCH_FLAGS     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTER_RULE      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INNER_RULE      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_INGRESS_REWRITE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_EGRESS_REWRITE  = 3'd4;

   localparam logic [1:0] TAG_NONE = 2'd0;

   typedef enum logic [1:0] {
      OP_NONE = 2'd0,
      OP_POP  = 2'd1,
      OP_PUSH = 2'd2,
      OP_SWAP = 2'd3
   } rw_op_type;

   typedef struct packed {
      logic untagged;
      logic valid;
   } match_flags_type;

   typedef struct packed {
      logic [11:0] vid_high;
      logic [11:0] vid_low;
      logic        ptag_ok;
      logic [7:0]  cos_mask;
      logic [1:0]  kind;
   } rule_type;

   typedef struct packed {
      logic [11:0] vid;
      logic [2:0]  cos;
      logic [1:0]  kind;
   } tag_type;

   typedef struct packed {
      tag_type    inner_tag;
      tag_type    outer_tag;
      logic [1:0] pop_count;
      rw_op_type  op;
   } rewrite_type;

   typedef struct packed {
      logic        direction;
      logic [1:0]  outer_type;
      logic [2:0]  outer_cos;
      logic [11:0] outer_vid;
      logic [1:0]  inner_type;
      logic [2:0]  inner_cos;
      logic [11:0] inner_vid;
   } req_type;

   typedef struct packed {
      logic        matched;
      logic [1:0]  match_depth;
      logic [1:0]  new_outer_type;
      logic [2:0]  new_outer_cos;
      logic [11:0] new_outer_vid;
      logic [1:0]  new_inner_type;
      logic [2:0]  new_inner_cos;
      logic [11:0] new_inner_vid;
      logic        push_skipped;
   } rsp_type;

   typedef struct packed {
      logic       matched;
      logic [1:0] depth;
   } match_result_type;

   typedef struct packed {
      tag_type outer_tag;
      tag_type inner_tag;
      logic    push_skipped;
   } rewrite_result_type;

endpackage

// ===== src/vtmr_match.sv =====
module vtmr_match (
   input  vtmr_pkg::req_type          req,
   input  vtmr_pkg::match_flags_type  flags,
   input  vtmr_pkg::rule_type         outer_rule,
   input  vtmr_pkg::rule_type         inner_rule,
   output vtmr_pkg::match_result_type result
);
   import vtmr_pkg::*;

   function automatic logic tag_ok(rule_type r, logic [1:0] kind, logic [2:0] cos,
                                   logic [11:0] vid);
      logic ok;
      if (r.kind != kind) begin
         ok = 1'b0;
      end else if (r.cos_mask != 8'd0 && !r.cos_mask[cos]) begin
         ok = 1'b0;
      end else if (vid == 12'd0) begin
         ok = r.ptag_ok;
      end else begin
         ok = (vid >= r.vid_low) && (vid <= r.vid_high);
      end
      return ok;
   endfunction

   logic outer_ok;
   logic inner_ok;

   assign outer_ok = tag_ok(outer_rule, req.outer_type, req.outer_cos, req.outer_vid);
   assign inner_ok = tag_ok(inner_rule, req.inner_type, req.inner_cos, req.inner_vid);

   always_comb begin
      result = '0;
      if (flags.valid) begin
         if (outer_rule.kind != TAG_NONE) begin
            if (inner_rule.kind != TAG_NONE) begin
               if (outer_ok && inner_ok) begin
                  result.matched = 1'b1;
                  result.depth   = 2'd2;
               end
            end else if (outer_ok) begin
               result.matched = 1'b1;
               result.depth   = 2'd1;
            end
         end else if (flags.untagged && req.outer_type == TAG_NONE) begin
            result.matched = 1'b1;
         end
      end
   end

endmodule

// ===== src/vtmr_rewrite.sv =====
module vtmr_rewrite (
   input  vtmr_pkg::req_type            req,
   input  vtmr_pkg::rewrite_type        ingress_rw,
   input  vtmr_pkg::rewrite_type        egress_rw,
   output vtmr_pkg::rewrite_result_type result
);
   import vtmr_pkg::*;

   rewrite_type rw;
   tag_type     in_outer;
   tag_type     in_inner;

   assign rw       = req.direction ? egress_rw : ingress_rw;
   assign in_outer = '{vid: req.outer_vid, cos: req.outer_cos, kind: req.outer_type};
   assign in_inner = '{vid: req.inner_vid, cos: req.inner_cos, kind: req.inner_type};

   always_comb begin
      result.outer_tag    = in_outer;
      result.inner_tag    = in_inner;
      result.push_skipped = 1'b0;
      case (rw.op)
         OP_POP: begin
            if (rw.pop_count == 2'd1) begin
               result.outer_tag = in_inner;
               result.inner_tag = '0;
            end else if (rw.pop_count == 2'd2) begin
               result.outer_tag = '0;
               result.inner_tag = '0;
            end
         end
         OP_PUSH: begin
            if (in_outer.kind == TAG_NONE) begin
               result.outer_tag = rw.outer_tag;
               result.inner_tag = rw.inner_tag;
            end else if (in_inner.kind == TAG_NONE) begin
               result.outer_tag = rw.outer_tag;
               result.inner_tag = in_outer;
            end else begin
               // two tags already present: leave frame as is
               result.push_skipped = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== src/vlan_tag_match_rewrite_top.sv =====
// Path: an accepted item is held in the input register (s1), then loaded into the
// result register, which drives rsp_valid and rsp_data.
// Throughput: one item per cycle while rsp_ready stays high; a stalled result
// holds the input register, and once both registers are full req_ready drops
// until the result is taken.
// Reset: synchronous, active high; clears valids and all config registers.
module vlan_tag_match_rewrite_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  vtmr_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output vtmr_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [vtmr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [vtmr_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import vtmr_pkg::*;

   match_flags_type flags_ff,    flags_in;
   rule_type        outer_ff,    outer_in;
   rule_type        inner_ff,    inner_in;
   rewrite_type     ingress_ff,  ingress_in;
   rewrite_type     egress_ff,   egress_in;

   logic    s1_valid_ff,  s1_valid_in;
   req_type s1_data_ff,   s1_data_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff,  rsp_data_in;

   logic req_accept;
   logic rsp_load;

   match_result_type   match_res;
   rewrite_result_type rw_res;

   // configuration writes
   always_comb begin
      flags_in   = flags_ff;
      outer_in   = outer_ff;
      inner_in   = inner_ff;
      ingress_in = ingress_ff;
      egress_in  = egress_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_MATCH_FLAGS:     flags_in   = match_flags_type'(csr_wdata[1:0]);
            CSR_OUTER_RULE:      outer_in   = rule_type'(csr_wdata[RULE_W-1:0]);
            CSR_INNER_RULE:      inner_in   = rule_type'(csr_wdata[RULE_W-1:0]);
            CSR_INGRESS_REWRITE: ingress_in = rewrite_type'(csr_wdata[REWRITE_W-1:0]);
            CSR_EGRESS_REWRITE:  egress_in  = rewrite_type'(csr_wdata[REWRITE_W-1:0]);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff   <= '0;
         outer_ff   <= '0;
         inner_ff   <= '0;
         ingress_ff <= '0;
         egress_ff  <= '0;
      end else begin
         flags_ff   <= flags_in;
         outer_ff   <= outer_in;
         inner_ff   <= inner_in;
         ingress_ff <= ingress_in;
         egress_ff  <= egress_in;
      end
   end

   // pipeline control: input stage advances when the result stage frees up
   assign rsp_load   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || rsp_load;
   assign req_accept = req_valid && req_ready;

   assign s1_valid_in  = req_accept ? 1'b1 : (rsp_load ? 1'b0 : s1_valid_ff);
   assign s1_data_in   = req_accept ? req_data : s1_data_ff;
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   vtmr_match u_match (
      .req        (s1_data_ff),
      .flags      (flags_ff),
      .outer_rule (outer_ff),
      .inner_rule (inner_ff),
      .result     (match_res)
   );

   vtmr_rewrite u_rewrite (
      .req        (s1_data_ff),
      .ingress_rw (ingress_ff),
      .egress_rw  (egress_ff),
      .result     (rw_res)
   );

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (rsp_load) begin
         rsp_data_in.matched        = match_res.matched;
         rsp_data_in.match_depth    = match_res.depth;
         rsp_data_in.new_outer_type = rw_res.outer_tag.kind;
         rsp_data_in.new_outer_cos  = rw_res.outer_tag.cos;
         rsp_data_in.new_outer_vid  = rw_res.outer_tag.vid;
         rsp_data_in.new_inner_type = rw_res.inner_tag.kind;
         rsp_data_in.new_inner_cos  = rw_res.inner_tag.cos;
         rsp_data_in.new_inner_vid  = rw_res.inner_tag.vid;
         rsp_data_in.push_skipped   = rw_res.push_skipped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted item not held in input stage");

   a_unmatched_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.matched || rsp_data_ff.match_depth == 2'd0))
      else $error("nonzero depth on unmatched item");

   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.match_depth != 2'd3)
      else $error("match depth out of range");

   a_skip_keeps_tags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.push_skipped) |->
         (rsp_data_ff.new_outer_type != TAG_NONE && rsp_data_ff.new_inner_type != TAG_NONE))
      else $error("push skipped on frame without two tags");

endmodule
